// File: hdl/alpha_fade_wait_timer_defines.svh
// Assertion macros of the alpha fade wait timer checker
`ifndef ALPHA_FADE_WAIT_TIMER_DEFINES_SVH
`define ALPHA_FADE_WAIT_TIMER_DEFINES_SVH

// checked only while out of reset
`define AFWT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("alpha_fade_wait_timer: check failed");

// checked at every edge, reset included
`define AFWT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("alpha_fade_wait_timer: reset check failed");

`endif

// File: hdl/afwt_pkg.sv
// Shared constants, codes and controller/datapath types of the alpha fade wait timer
package afwt_pkg;

	localparam int DURATION_BITS = 16;
	localparam int ALPHA_BITS    = 8;
	localparam int PROD_BITS     = DURATION_BITS + ALPHA_BITS;
	localparam int DIV_CNT_BITS  = $clog2(ALPHA_BITS);

	localparam logic [ALPHA_BITS-1:0]   AMAX      = {ALPHA_BITS{1'b1}};
	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST  = DIV_CNT_BITS'(ALPHA_BITS - 1);

	typedef enum logic [1:0] {
		ACT_TICK,
		ACT_SET_WAIT,
		ACT_SET_FADE_OUT,
		ACT_SET_FADE_IN
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic prep;
		logic mul;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

endpackage

// File: hdl/afwt_ctrl.sv
// Controller state machine: sequences update, alpha divide and result beat
module afwt_ctrl
	import afwt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_EXEC;
			ST_EXEC: state_nx = ST_PREP;
			ST_PREP: state_nx = status.need_div ? ST_MUL : ST_FIN;
			ST_MUL:  state_nx = ST_DIV;
			ST_DIV:  if (status.div_done) state_nx = ST_FIN;
			ST_FIN:  if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.prep     = (state_q == ST_PREP);
		cmd.mul      = (state_q == ST_MUL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hdl/afwt_dp.sv
// Datapath: timers, visibility, opacity, restoring alpha divider, result register
module afwt_dp
	import afwt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_status_t               status,
	input  logic [1:0]               action,
	input  logic [DURATION_BITS-1:0] duration,
	output logic                     visible,
	output logic [ALPHA_BITS-1:0]    alpha,
	output logic                     busy_res
);

	action_t                  act_q;
	logic [DURATION_BITS-1:0] dur_q;

	logic [DURATION_BITS-1:0] wait_len_q, wait_cnt_q;
	logic [DURATION_BITS-1:0] fo_len_q, fo_cnt_q;
	logic [DURATION_BITS-1:0] fi_len_q, fi_cnt_q;
	logic                     shown_q;
	logic [ALPHA_BITS-1:0]    opacity_q;

	logic                     need_div_q;
	logic                     sel_fi_q;
	logic [DURATION_BITS-1:0] op_q;
	logic [DURATION_BITS-1:0] dvs_q;
	logic [DURATION_BITS-1:0] rem_q;
	logic [ALPHA_BITS-1:0]    quo_q;
	logic [DIV_CNT_BITS-1:0]  div_cnt_q;

	logic                     vis_q;
	logic [ALPHA_BITS-1:0]    alpha_q;
	logic                     busy_q;

	logic [DURATION_BITS-1:0] wait_inc, fo_inc, fi_inc;
	logic [PROD_BITS-1:0]     prod;
	logic [DURATION_BITS:0]   trial;
	logic [DURATION_BITS:0]   diff;
	logic                     fits;
	logic                     busy_now;
	logic                     fade_step;

	assign wait_inc = wait_cnt_q + DURATION_BITS'(1);
	assign fo_inc   = fo_cnt_q + DURATION_BITS'(1);
	assign fi_inc   = fi_cnt_q + DURATION_BITS'(1);

	// AMAX * op as a shift and subtract
	assign prod  = {op_q, {ALPHA_BITS{1'b0}}} - {{ALPHA_BITS{1'b0}}, op_q};
	assign trial = {rem_q, quo_q[ALPHA_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	assign busy_now = (wait_len_q != '0) || (fo_len_q != '0) || (fi_len_q != '0);

	// tick that moves a fade without ending it
	assign fade_step = (act_q == ACT_TICK) && (wait_len_q == '0) &&
		((fo_len_q != '0) ? (fo_inc != fo_len_q) : ((fi_len_q != '0) && (fi_inc != fi_len_q)));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action_t'(action);
			dur_q <= duration;
		end
		if (cmd.prep) begin
			op_q  <= sel_fi_q ? fi_cnt_q : (fo_len_q - fo_cnt_q);
			dvs_q <= sel_fi_q ? fi_len_q : fo_len_q;
		end
		if (cmd.mul) begin
			rem_q <= prod[PROD_BITS-1:ALPHA_BITS];
			quo_q <= prod[ALPHA_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? diff[DURATION_BITS-1:0] : trial[DURATION_BITS-1:0];
			quo_q <= {quo_q[ALPHA_BITS-2:0], fits};
		end
		if (cmd.out_load) begin
			vis_q   <= shown_q;
			alpha_q <= need_div_q ? quo_q : opacity_q;
			busy_q  <= busy_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_len_q <= '0;
			wait_cnt_q <= '0;
			fo_len_q   <= '0;
			fo_cnt_q   <= '0;
			fi_len_q   <= '0;
			fi_cnt_q   <= '0;
			shown_q    <= 1'b1;
			opacity_q  <= AMAX;
			need_div_q <= 1'b0;
			sel_fi_q   <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			if (cmd.exec) begin
				need_div_q <= fade_step;
				unique case (act_q)
					ACT_TICK: begin
						if (wait_len_q != '0) begin
							if (wait_inc == wait_len_q) begin
								wait_len_q <= '0;
								wait_cnt_q <= '0;
								shown_q    <= 1'b0;
							end else begin
								wait_cnt_q <= wait_inc;
							end
						end else if (fo_len_q != '0) begin
							if (fo_inc == fo_len_q) begin
								fo_len_q  <= '0;
								fo_cnt_q  <= '0;
								opacity_q <= AMAX;
								shown_q   <= 1'b0;
							end else begin
								fo_cnt_q   <= fo_inc;
								sel_fi_q   <= 1'b0;
							end
						end else if (fi_len_q != '0) begin
							if (fi_inc == fi_len_q) begin
								fi_len_q  <= '0;
								fi_cnt_q  <= '0;
								opacity_q <= AMAX;
								shown_q   <= 1'b1;
							end else begin
								fi_cnt_q   <= fi_inc;
								sel_fi_q   <= 1'b1;
							end
						end
					end
					ACT_SET_WAIT: begin
						wait_len_q <= dur_q;
						wait_cnt_q <= '0;
						if (dur_q != '0) shown_q <= 1'b1;
					end
					ACT_SET_FADE_OUT: begin
						if (dur_q != '0) begin
							fo_len_q <= dur_q;
							fo_cnt_q <= '0;
						end
					end
					ACT_SET_FADE_IN: begin
						if (dur_q != '0) begin
							fi_len_q <= dur_q;
							fi_cnt_q <= '0;
							shown_q  <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.mul) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
			end
			if (cmd.out_load && need_div_q) begin
				opacity_q <= quo_q;
			end
		end
	end

	assign status.need_div = need_div_q;
	assign status.div_done = cmd.div_step && (div_cnt_q == DIV_LAST);

	assign visible  = vis_q;
	assign alpha    = alpha_q;
	assign busy_res = busy_q;

endmodule

// File: hdl/alpha_fade_wait_timer.sv
// Top level of the alpha fade wait timer: controller plus datapath
//
// Input channel (in_valid/in_stall) carries one action per beat: tick, set
// wait, set fade-out or set fade-in, with a 16-bit frame duration.
// Output channel (out_valid/out_stall) returns one beat per input beat:
// visible, alpha (255 opaque) and busy_res.
// One item is worked on at a time; in_stall is low only in the idle state.
// Set commands, plain ticks and ticks that end a timer skip the divider;
// a tick that moves a fade first runs the restoring divider, which makes
// one quotient bit per cycle, to work out the new alpha.
// The finished beat sits in an output register, so the next item is taken
// while it waits; a stalled receiver holds the block in its final state
// only once the following result is ready.
// Reset: no timers loaded, shown with opacity 255, out_valid low, ready for input.
module alpha_fade_wait_timer
	import afwt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               action,
	input  logic [DURATION_BITS-1:0] duration,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     visible,
	output logic [ALPHA_BITS-1:0]    alpha,
	output logic                     busy_res
);

	dp_cmd_t    cmd;
	dp_status_t status;

	afwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	afwt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.action   (action),
		.duration (duration),
		.visible  (visible),
		.alpha    (alpha),
		.busy_res (busy_res)
	);

endmodule

// File: hdl/afwt_chk.sv
// Port-level checker of the alpha fade wait timer and its bind
`include "alpha_fade_wait_timer_defines.svh"

module afwt_chk
	import afwt_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic                     visible,
	input logic [ALPHA_BITS-1:0]    alpha,
	input logic                     busy_res
);

	`AFWT_ASSERT(a_one_inflight, clk, arst_n, in_valid && !in_stall |=> in_stall)
	`AFWT_ASSERT(a_idle_alpha_full, clk, arst_n, out_valid && !busy_res |-> alpha == AMAX)
	`AFWT_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(alpha) && $stable(visible) && $stable(busy_res))
	`AFWT_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid && !in_stall)

endmodule

bind alpha_fade_wait_timer afwt_chk u_afwt_chk (.*);
